[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property violated");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property violated");

`endif

[sv/csp_pkg.sv]
package csp_pkg;

	// Field widths
	localparam int COUNT_BITS  = 28;
	localparam int LENGTH_BITS = 40;
	localparam int BYTE_BITS   = 8;

	// Wide enough for the length sum to never wrap before saturation
	localparam int SUM_BITS =
		((LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS) + 2;
	// Room for count * 10 + 9 before saturation
	localparam int PROD_BITS = COUNT_BITS + 4;
	localparam int DIGIT_RADIX = 10;

	// Characters
	localparam logic [BYTE_BITS-1:0] CHAR_0 = 8'h30;
	localparam logic [BYTE_BITS-1:0] CHAR_9 = 8'h39;
	localparam logic [BYTE_BITS-1:0] CHAR_D = 8'h44;
	localparam logic [BYTE_BITS-1:0] CHAR_I = 8'h49;
	localparam logic [BYTE_BITS-1:0] CHAR_H = 8'h48;
	localparam logic [BYTE_BITS-1:0] CHAR_M = 8'h4D;
	localparam logic [BYTE_BITS-1:0] CHAR_N = 8'h4E;
	localparam logic [BYTE_BITS-1:0] CHAR_P = 8'h50;
	localparam logic [BYTE_BITS-1:0] CHAR_S = 8'h53;

	typedef enum logic [1:0] {
		KIND_TOKEN = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		OP_D = 3'd0,
		OP_I = 3'd1,
		OP_H = 3'd2,
		OP_M = 3'd3,
		OP_N = 3'd4,
		OP_P = 3'd5,
		OP_S = 3'd6
	} op_t;

	localparam int KIND_BITS = $bits(kind_t);
	localparam int OP_BITS   = $bits(op_t);

	// Output tdata layout, lowest bit first
	localparam int KIND_LSB      = 0;
	localparam int OP_LSB        = KIND_LSB + KIND_BITS;
	localparam int COUNT_LSB     = OP_LSB + OP_BITS;
	localparam int LENGTH_LSB    = COUNT_LSB + COUNT_BITS;
	localparam int PAYLOAD_BITS  = LENGTH_LSB + LENGTH_BITS;
	localparam int OUT_DATA_BITS = ((PAYLOAD_BITS + 7) / 8) * 8;

	// Output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		kind_t                    kind;
		op_t                      op;
		logic [COUNT_BITS-1:0]    count;
		logic [LENGTH_BITS-1:0]   length;
		logic                     last;
	} result_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_decode_t;

	function automatic op_decode_t decode_op(logic [BYTE_BITS-1:0] b);
		op_decode_t d;
		d.valid = 1'b1;
		case (b)
			CHAR_D:  d.op = OP_D;
			CHAR_I:  d.op = OP_I;
			CHAR_H:  d.op = OP_H;
			CHAR_M:  d.op = OP_M;
			CHAR_N:  d.op = OP_N;
			CHAR_P:  d.op = OP_P;
			CHAR_S:  d.op = OP_S;
			default: begin
				d.valid = 1'b0;
				d.op    = OP_D;
			end
		endcase
		return d;
	endfunction

endpackage

[sv/cigar_string_parser.sv]
// CIGAR string parser. Takes one ASCII byte per transfer on the input stream
// (tlast marks the final byte of a string) and emits token, error and
// end-of-string results on the output stream, one result per transfer. A
// byte is registered in an input stage, then decoded and pushed into a
// four-entry result queue once the queue has room, and its results leave
// from the head of that queue. One byte is taken per cycle as long as the
// queue has two free entries; a byte that gives two results (an op or a bad
// byte on the final byte of a string) needs two output transfers, so a run
// of such bytes is limited by the single output port.
module cigar_string_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// text_byte
	input  logic [csp_pkg::BYTE_BITS-1:0]     s_axis_tdata,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// result_kind, op_code, run_count, extra_length, zero pad
	output logic [csp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	output logic                              m_axis_tlast
);
	import csp_pkg::*;

	localparam logic [FIFO_AW:0] FIFO_ROOM = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

	// Input stage
	logic                   valid_s1;
	logic [BYTE_BITS-1:0]   byte_s1;
	logic                   eos_s1;
	logic                   fire_s1;

	// Parser state
	logic [COUNT_BITS-1:0]  digit_q, digit_d;
	logic [LENGTH_BITS-1:0] length_q, length_d;
	logic                   error_q, error_d;

	// Result queue
	result_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]       count_q;
	logic                   pop;

	// Decode results
	result_t                res0, res1;
	logic [1:0]             n_push;
	op_decode_t             dec;
	logic [PROD_BITS-1:0]   prod;
	logic [COUNT_BITS-1:0]  digit_sat;
	logic signed [SUM_BITS-1:0] len_ext, cnt_ext, len_sum;
	logic [SUM_BITS-LENGTH_BITS:0] sum_hi;
	logic [LENGTH_BITS-1:0] len_upd;
	logic                   is_digit;
	result_t                head;

	assign fire_s1       = valid_s1 && (count_q <= FIFO_ROOM);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// Register the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	// Digit accumulate with saturation
	always_comb begin
		prod = PROD_BITS'(digit_q) * PROD_BITS'(DIGIT_RADIX)
			+ PROD_BITS'(byte_s1 - CHAR_0);
		digit_sat = (|prod[PROD_BITS-1:COUNT_BITS]) ? '1 : prod[COUNT_BITS-1:0];
	end

	// Extra length update with signed saturation
	always_comb begin
		dec     = decode_op(byte_s1);
		len_ext = SUM_BITS'(signed'(length_q));
		cnt_ext = signed'(SUM_BITS'(digit_q));
		case (dec.op)
			OP_I:       len_sum = len_ext - cnt_ext;
			OP_D, OP_N: len_sum = len_ext + cnt_ext;
			default:    len_sum = len_ext;
		endcase
		sum_hi = len_sum[SUM_BITS-1:LENGTH_BITS-1];
		if ((&sum_hi) || !(|sum_hi)) begin
			len_upd = len_sum[LENGTH_BITS-1:0];
		end else if (len_sum[SUM_BITS-1]) begin
			len_upd = {1'b1, {(LENGTH_BITS-1){1'b0}}};
		end else begin
			len_upd = {1'b0, {(LENGTH_BITS-1){1'b1}}};
		end
	end

	// Build results and next state for the registered byte
	always_comb begin
		is_digit = byte_s1 inside {[CHAR_0:CHAR_9]};
		digit_d  = digit_q;
		length_d = length_q;
		error_d  = error_q;
		n_push   = 2'd0;
		res0     = '{kind: KIND_TOKEN, op: OP_D, count: '0, length: '0, last: 1'b0};
		res1     = res0;

		if (!error_q) begin
			if (is_digit) begin
				digit_d = digit_sat;
			end else if (dec.valid) begin
				length_d    = len_upd;
				digit_d     = '0;
				res0.kind   = KIND_TOKEN;
				res0.op     = dec.op;
				res0.count  = digit_q;
				res0.length = len_upd;
				res0.last   = !eos_s1;
				n_push      = 2'd1;
			end else begin
				error_d     = 1'b1;
				res0.kind   = KIND_ERROR;
				res0.length = length_q;
				res0.last   = !eos_s1;
				n_push      = 2'd1;
			end
		end

		// Append the end summary and clear the state
		if (eos_s1) begin
			if (n_push == 2'd0) begin
				res0.kind   = KIND_END;
				res0.op     = OP_D;
				res0.count  = '0;
				res0.length = length_d;
				res0.last   = 1'b1;
			end else begin
				res1.kind   = KIND_END;
				res1.length = length_d;
				res1.last   = 1'b1;
			end
			n_push   = n_push + 2'd1;
			digit_d  = '0;
			length_d = '0;
			error_d  = 1'b0;
		end
	end

	// Advance parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q  <= '0;
			length_q <= '0;
			error_q  <= 1'b0;
		end else if (fire_s1) begin
			digit_q  <= digit_d;
			length_q <= length_d;
			error_q  <= error_d;
		end
	end

	// Write results into the queue
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			if (n_push != 2'd0) begin
				fifo_q[wr_ptr_q] <= res0;
			end
			if (n_push == 2'd2) begin
				fifo_q[wr_ptr_q + FIFO_AW'(1)] <= res1;
			end
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire_s1) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW + 1)'(fire_s1 ? n_push : 2'd0)
				- (FIFO_AW + 1)'(pop);
		end
	end

	// Present the queue head
	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tlast  = head.last;

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[KIND_LSB +: KIND_BITS]     = head.kind;
		m_axis_tdata[OP_LSB +: OP_BITS]         = head.op;
		m_axis_tdata[COUNT_LSB +: COUNT_BITS]   = head.count;
		m_axis_tdata[LENGTH_LSB +: LENGTH_BITS] = head.length;
	end

endmodule

[sv/csp_checker.sv]
`include "assert_macros.svh"

module csp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	// text_byte
	input logic [csp_pkg::BYTE_BITS-1:0]     s_axis_tdata,
	input logic                              s_axis_tlast,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	// result_kind, op_code, run_count, extra_length, zero pad
	input logic [csp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	input logic                              m_axis_tlast
);
	import csp_pkg::*;

	logic [KIND_BITS-1:0]   kind;
	logic [OUT_DATA_BITS:0] out_word;
	logic                   out_stall;
	logic                   kind_ok;
	logic                   fields_clear;

	assign kind         = m_axis_tdata[KIND_LSB +: KIND_BITS];
	assign out_word     = {m_axis_tlast, m_axis_tdata};
	assign out_stall    = m_axis_tvalid && !m_axis_tready;
	assign kind_ok      = (kind == KIND_TOKEN) || (kind == KIND_ERROR) || (kind == KIND_END);
	assign fields_clear = (m_axis_tdata[OP_LSB +: OP_BITS] == '0)
		&& (m_axis_tdata[COUNT_LSB +: COUNT_BITS] == '0);

	// A stalled result holds its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))

	// Only the three result kinds appear
	`ASSERT_IMPLIES(a_kind_legal, clk, arst_n, m_axis_tvalid, kind_ok)

	// Error and end results carry no op and no count
	`ASSERT_IMPLIES(a_non_token_clear, clk, arst_n, m_axis_tvalid && (kind != KIND_TOKEN), fields_clear)

	// An end summary is always the last result of its byte
	`ASSERT_IMPLIES(a_end_is_last, clk, arst_n, m_axis_tvalid && (kind == KIND_END), m_axis_tlast)

	// With no result waiting the input is always open
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind cigar_string_parser csp_checker u_csp_checker (.*);
